// ===== hdl/cdp_pkg.sv =====
`default_nettype none

package cdp_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int ID_BITS       = 16;
  localparam int DURATION_BITS = 16;

  // Only the low 16 bits of either field reach the ports.
  localparam int ID_W  = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int DUR_W = (DURATION_BITS < 16) ? DURATION_BITS : 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_CLASSES = 4;
  localparam int CLASS_W     = 2;

  localparam logic [CLASS_W-1:0] CLASS_REGULAR  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SILVER   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_GOLD     = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_PLATINUM = 2'd3;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] dur;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cdp_cell.sv =====
`default_nettype none

module cdp_cell (
  input  wire                   clk,
  input  wire                   load,
  input  wire                   shift,
  input  wire cdp_pkg::entry_t  load_data,
  input  wire cdp_pkg::entry_t  shift_data,
  output cdp_pkg::entry_t       data
);
  import cdp_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  // A push lands in the first free cell; a pop moves every cell one step toward the head.
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = shift_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hdl/cdp_queue.sv =====
`default_nettype none

module cdp_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire cdp_pkg::queue_ctl_t  ctl,
  input  wire cdp_pkg::entry_t      push_data,
  output cdp_pkg::entry_t           head,
  output cdp_pkg::queue_stat_t      stat
);
  import cdp_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  entry_t cell_data [QUEUE_DEPTH];
  entry_t nbr_data  [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr_data[i] = cell_data[i];
    end else begin : g_mid
      assign nbr_data[i] = cell_data[i+1];
    end

    cdp_cell u_cell (
      .clk        (clk),
      .load       (ctl.push && (count_r == CNT_W'(i))),
      .shift      (ctl.pop),
      .load_data  (push_data),
      .shift_data (nbr_data[i]),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head       = cell_data[0];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.last  = (count_r == CNT_W'(1));

endmodule

`default_nettype wire

// ===== hdl/four_class_priority_call_dispatcher.sv =====
`default_nettype none

// Strict-priority call dispatcher with four class queues and one server.
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. in_op selects an arrival (push onto the class queue named by
// in_call_class) or a tick (answer the head of the highest non-empty class if
// the server is free, then count down the busy time and advance the tick).
// Result channel: every transaction yields exactly one result, shown on the
// out_ ports for a single cycle with out_valid high, in the cycle after the
// transaction is taken. The receiver cannot stall, so results never wait.
// Throughput is one transaction per cycle: each class queue is a chain of
// cells whose head is always the first cell, so a pop is a single shift
// and the priority pick reads four fixed heads. busy is therefore never raised.
// A full queue drops the arrival and flags it in out_dropped.
// Synchronous reset empties all queues and clears the busy and tick counters;
// the cell contents are not cleared, since only written cells are ever read.
module four_class_priority_call_dispatcher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_op,
  input  wire  [1:0]  in_call_class,
  input  wire  [15:0] in_caller_id,
  input  wire  [15:0] in_service_ticks,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_dropped,
  output logic [31:0] out_tick_number,
  output logic        out_answered,
  output logic [15:0] out_answered_id,
  output logic [1:0]  out_answered_class,
  output logic [15:0] out_busy_left,
  output logic        out_all_idle
);
  import cdp_pkg::*;

  queue_ctl_t  q_ctl  [NUM_CLASSES];
  queue_stat_t q_stat [NUM_CLASSES];
  entry_t      q_head [NUM_CLASSES];
  entry_t      push_data;

  logic [DUR_W-1:0] busy_cnt_r, busy_cnt_nxt;
  logic [31:0]      tick_r, tick_nxt;

  logic               accept;
  logic               push_ok;
  logic               pick_any;
  logic [CLASS_W-1:0] pick_class;
  entry_t             pick_entry;
  logic [DUR_W-1:0]   busy_loaded;
  logic               idle_after;

  logic               valid_r;
  logic               kind_r, dropped_r, answered_r, all_idle_r;
  logic [31:0]        tick_no_r;
  logic [15:0]        ans_id_r, busy_left_r;
  logic [CLASS_W-1:0] ans_class_r;

  logic               kind_nxt, dropped_nxt, answered_nxt;
  logic [15:0]        ans_id_nxt;
  logic [CLASS_W-1:0] ans_class_nxt;

  // busy is tied low, so the command port never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign push_data.id  = in_caller_id[ID_W-1:0];
  assign push_data.dur = in_service_ticks[DUR_W-1:0];

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_queue
    cdp_queue u_queue (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (q_ctl[c]),
      .push_data (push_data),
      .head      (q_head[c]),
      .stat      (q_stat[c])
    );
  end

  // Fixed priority pick: platinum first, regular last.
  always_comb begin
    pick_any   = 1'b1;
    pick_class = CLASS_REGULAR;
    if (!q_stat[CLASS_PLATINUM].empty) begin
      pick_class = CLASS_PLATINUM;
    end else if (!q_stat[CLASS_GOLD].empty) begin
      pick_class = CLASS_GOLD;
    end else if (!q_stat[CLASS_SILVER].empty) begin
      pick_class = CLASS_SILVER;
    end else if (!q_stat[CLASS_REGULAR].empty) begin
      pick_class = CLASS_REGULAR;
    end else begin
      pick_any = 1'b0;
    end
    pick_entry = q_head[pick_class];
  end

  assign push_ok = accept && (in_op == OP_ARRIVAL) && !q_stat[in_call_class].full;

  always_comb begin
    busy_cnt_nxt  = busy_cnt_r;
    tick_nxt      = tick_r;
    kind_nxt      = in_op;
    dropped_nxt   = 1'b0;
    answered_nxt  = 1'b0;
    ans_id_nxt    = '0;
    ans_class_nxt = CLASS_REGULAR;
    busy_loaded   = busy_cnt_r;
    idle_after    = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      q_ctl[c].push = push_ok && (in_call_class == CLASS_W'(c));
      q_ctl[c].pop  = 1'b0;
    end

    if (accept && (in_op == OP_TICK)) begin
      if ((busy_cnt_r == '0) && pick_any) begin
        q_ctl[pick_class].pop = 1'b1;
        answered_nxt  = 1'b1;
        ans_id_nxt    = 16'(pick_entry.id);
        ans_class_nxt = pick_class;
        busy_loaded   = pick_entry.dur;
      end
      busy_cnt_nxt = (busy_loaded != '0) ? busy_loaded - DUR_W'(1) : busy_loaded;
      tick_nxt     = tick_r + 32'd1;
    end else if (accept) begin
      dropped_nxt = !push_ok;
    end

    // Idle is judged on the queue state that this transaction leaves behind.
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (q_ctl[c].push || !(q_stat[c].empty || (q_ctl[c].pop && q_stat[c].last))) begin
        idle_after = 1'b0;
      end
    end
    if (busy_cnt_nxt != '0) begin
      idle_after = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= '0;
      tick_r     <= '0;
      valid_r    <= 1'b0;
    end else begin
      busy_cnt_r <= busy_cnt_nxt;
      tick_r     <= tick_nxt;
      valid_r    <= accept;
    end
  end

  // Result payload; only meaningful in the cycle where valid_r is high.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= kind_nxt;
      dropped_r   <= dropped_nxt;
      tick_no_r   <= tick_r;
      answered_r  <= answered_nxt;
      ans_id_r    <= ans_id_nxt;
      ans_class_r <= ans_class_nxt;
      busy_left_r <= 16'(busy_cnt_nxt);
      all_idle_r  <= idle_after;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_dropped        = dropped_r;
  assign out_tick_number    = tick_no_r;
  assign out_answered       = answered_r;
  assign out_answered_id    = ans_id_r;
  assign out_answered_class = ans_class_r;
  assign out_busy_left      = busy_left_r;
  assign out_all_idle       = all_idle_r;

`ifndef NO_ASSERTIONS
  // Each taken transaction produces its result in the very next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("taken transaction produced no result");

  // A tick report never carries a drop flag, and an acknowledgement never answers.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_TICK) ? !out_dropped : !out_answered))
    else $error("result fields inconsistent with kind");

  // A call is answered only when the server was free at that tick.
  a_answer_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_answered) |-> ($past(busy_cnt_r) == '0))
    else $error("call answered while server busy");

  // Reported idle implies the reported busy count is zero.
  a_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_idle) |-> (out_busy_left == 16'd0))
    else $error("idle reported with busy time left");
`endif

endmodule

`default_nettype wire
